FILE: rtl/uuencode_line_encoder_defines.svh
// ----------------------------------------------------------------------------
// uuencode line encoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UUENCODE_LINE_ENCODER_DEFINES_SVH
`define UUENCODE_LINE_ENCODER_DEFINES_SVH

// The consequent must hold in every cycle in which the antecedent holds.
`define UUEL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The expression must never hold.
`define UUEL_ASSERT_NEVER(lbl, expr, msg) \
    `UUEL_ASSERT_IMPL(lbl, 1'b1, !(expr), msg)

`endif

FILE: rtl/uuel_pkg.sv
// ----------------------------------------------------------------------------
// uuencode line encoder package
// Request and result types, job descriptors and the character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package uuel_pkg;

    localparam int CNT_W       = 6;
    localparam int MAX_RESULTS = 64;

    localparam logic [6:0] CH_NL     = 7'd10;
    localparam logic [6:0] CH_ZERO   = 7'h60;
    localparam logic [6:0] CH_OFFSET = 7'h20;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_uu_in;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_of_run;
    } t_uu_out;

    typedef struct packed {
        logic             line;
        logic             term;
        logic             bank;
        logic [CNT_W-1:0] count;
    } t_job;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    typedef struct packed {
        logic busy;
        logic line;
        logic bank;
    } t_bk_status;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    function automatic logic [6:0] uu_char(input logic [5:0] v);
        return (v == 6'd0) ? CH_ZERO : ({1'b0, v} + CH_OFFSET);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/uuencode_line_encoder.sv
// The length character of a line goes out first; each group of three bytes is then fetched
// from the line RAM before its four characters are emitted. A full default line has 62
// characters; bytes are taken one per cycle while the current write bank is free and the
// job queue is not full. Reset is synchronous and active low; it clears the busy, valid,
// phase, byte count and pointer state, while the back part's job fields and counters and
// the line RAM keep undefined contents with no clearing pass.
// ----------------------------------------------------------------------------
// uuencode line encoder
// Turns a byte stream into uuencode body lines, one character per result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uuencode_line_encoder_defines.svh"

module uuencode_line_encoder
    import uuel_pkg::*;
#(
    parameter int LINE_BYTES = 45
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_uu_in  i_data,
    output logic         o_stall,
    output logic         o_valid,
    output t_uu_out      o_data,
    input  wire logic    i_stall
);

    localparam int IDX_W     = $clog2(LINE_BYTES);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    t_job              q_in;
    t_job              q_out;
    t_rel              rel;
    t_bk_status        bk_stat;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              wr_busy_bank;

    uuel_front #(
        .LINE_BYTES(LINE_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_push  (q_push),
        .o_job   (q_in),
        .i_full  (q_full),
        .i_rel   (rel),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata)
    );

    uuel_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty)
    );

    uuel_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    uuel_back #(
        .LINE_BYTES(LINE_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_out),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_re    (ram_re),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata),
        .o_rel   (rel),
        .o_stat  (bk_stat),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    assign wr_busy_bank = ram_we && bk_stat.busy && bk_stat.line &&
                          (ram_waddr[ADDR_W-1] == bk_stat.bank);

    `UUEL_ASSERT_NEVER(a_queue_overflow, q_push && q_full, "Job pushed into a full queue.")
    `UUEL_ASSERT_NEVER(a_queue_underflow, q_pop && q_empty, "Job popped from an empty queue.")
    `UUEL_ASSERT_NEVER(a_bank_guard, wr_busy_bank, "Byte written into the bank being encoded.")

endmodule

`default_nettype wire

FILE: rtl/uuel_ram.sv
// ----------------------------------------------------------------------------
// uuencode line encoder RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module uuel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/uuel_job_fifo.sv
// ----------------------------------------------------------------------------
// uuencode line encoder job queue
// Two-entry queue of line jobs between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module uuel_job_fifo
    import uuel_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/uuel_front.sv
// ----------------------------------------------------------------------------
// uuencode line encoder front part
// Accepts requests, stores bytes into the current line bank and issues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module uuel_front
    import uuel_pkg::*;
#(
    parameter int LINE_BYTES = 45
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire t_uu_in                        i_data,
    output logic                               o_stall,
    output logic                               o_push,
    output t_job                               o_job,
    input  wire logic                          i_full,
    input  wire t_rel                          i_rel,
    output logic                               o_we,
    output logic [$clog2(LINE_BYTES):0]        o_waddr,
    output logic [7:0]                         o_wdata
);

    localparam int IDX_W = $clog2(LINE_BYTES);

    logic [CNT_W-1:0] r_count;
    logic             r_wbank;
    logic [1:0]       r_busy;
    logic [CNT_W-1:0] n_count;
    logic             n_wbank;
    logic [1:0]       n_busy;
    logic             accept;

    assign o_stall = i_full || r_busy[r_wbank];
    assign accept  = i_valid && !o_stall;
    assign o_we    = accept && (i_data.cmd == CMD_DATA);
    assign o_waddr = {r_wbank, r_count[IDX_W-1:0]};
    assign o_wdata = i_data.data_byte;

    always_comb begin
        n_count = r_count;
        n_wbank = r_wbank;
        n_busy  = r_busy;
        o_push  = 1'b0;
        o_job   = '{line: 1'b1, term: 1'b0, bank: r_wbank, count: r_count};
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (accept) begin
            if (i_data.cmd == CMD_DATA) begin
                if (r_count == CNT_W'(LINE_BYTES - 1)) begin
                    o_push          = 1'b1;
                    o_job.count     = CNT_W'(LINE_BYTES);
                    n_count         = '0;
                    n_wbank         = ~r_wbank;
                    n_busy[r_wbank] = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                o_push     = 1'b1;
                o_job.term = 1'b1;
                o_job.line = (r_count != '0);
                if (r_count != '0) begin
                    n_count         = '0;
                    n_wbank         = ~r_wbank;
                    n_busy[r_wbank] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_count <= n_count;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/uuel_back.sv
// ----------------------------------------------------------------------------
// uuencode line encoder back part
// Runs one job at a time: fetches byte groups and emits encoded characters.
// ----------------------------------------------------------------------------
`default_nettype none

module uuel_back
    import uuel_pkg::*;
#(
    parameter int LINE_BYTES = 45
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_job                          i_job,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    output logic                               o_re,
    output logic [$clog2(LINE_BYTES):0]        o_raddr,
    input  wire logic [7:0]                    i_rdata,
    output t_rel                               o_rel,
    output t_bk_status                         o_stat,
    output logic                               o_valid,
    output t_uu_out                            o_data,
    input  wire logic                          i_stall
);

    localparam int IDX_W = $clog2(LINE_BYTES);

    typedef enum logic [4:0] {
        P_LEN = 5'b00001,
        P_GRP = 5'b00010,
        P_NL  = 5'b00100,
        P_T1  = 5'b01000,
        P_T2  = 5'b10000
    } t_phase;

    logic             r_busy;
    t_job             r_job;
    t_phase           r_phase;
    logic [1:0]       r_k;
    logic [6:0]       r_eidx;
    logic [5:0]       r_ocnt;
    logic [6:0]       r_fidx;
    logic [1:0]       r_issued;
    logic [2:0]       r_gv;
    logic [7:0]       r_gb [3];
    logic [7:0]       r_cur [3];
    logic             r_pend;
    logic [1:0]       r_pslot;
    logic             r_out_valid;
    t_uu_out          r_out;

    logic             n_busy;
    t_job             n_job;
    t_phase           n_phase;
    logic [1:0]       n_k;
    logic [6:0]       n_eidx;
    logic [5:0]       n_ocnt;
    logic [6:0]       n_fidx;
    logic [1:0]       n_issued;
    logic [2:0]       n_gv;
    logic [7:0]       n_gb [3];
    logic [7:0]       n_cur [3];
    logic             n_pend;
    logic [1:0]       n_pslot;
    logic             n_out_valid;
    t_uu_out          n_out;

    logic [6:0]       n7;
    logic             can_issue;
    logic             in_range;
    logic             out_free;
    logic             gate;
    logic             nat_last;
    logic             last;
    logic             emit;
    logic [6:0]       ch;

    assign n7        = {1'b0, r_job.count};
    assign in_range  = (r_fidx < n7);
    assign can_issue = r_busy && r_job.line && (r_issued != 2'd3) &&
                       ((r_issued != 2'd0) || in_range);
    assign o_re      = can_issue && in_range;
    assign o_raddr   = {r_job.bank, r_fidx[IDX_W-1:0]};
    assign out_free  = !r_out_valid || !i_stall;
    assign o_pop     = !r_busy && !i_empty;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign o_stat    = '{busy: r_busy, line: r_job.line, bank: r_job.bank};

    always_comb begin
        gate     = 1'b1;
        nat_last = 1'b0;
        ch       = CH_NL;
        case (r_phase)
            P_LEN: ch = uu_char(r_job.count);
            P_GRP: begin
                case (r_k)
                    2'd0: begin
                        gate = &r_gv;
                        ch   = uu_char(r_gb[0][7:2]);
                    end
                    2'd1:    ch = uu_char({r_cur[0][1:0], r_cur[1][7:4]});
                    2'd2:    ch = uu_char({r_cur[1][3:0], r_cur[2][7:6]});
                    default: ch = uu_char(r_cur[2][5:0]);
                endcase
            end
            P_NL: begin
                ch       = CH_NL;
                nat_last = !r_job.term;
            end
            P_T1: ch = CH_ZERO;
            P_T2: begin
                ch       = CH_NL;
                nat_last = 1'b1;
            end
            default: gate = 1'b0;
        endcase
    end

    assign emit  = r_busy && out_free && gate;
    assign last  = nat_last || (r_ocnt == 6'(MAX_RESULTS - 1));
    assign o_rel = '{valid: emit && last && r_job.line, bank: r_job.bank};

    always_comb begin
        n_busy      = r_busy;
        n_job       = r_job;
        n_phase     = r_phase;
        n_k         = r_k;
        n_eidx      = r_eidx;
        n_ocnt      = r_ocnt;
        n_fidx      = r_fidx;
        n_issued    = r_issued;
        n_gv        = r_gv;
        n_gb        = r_gb;
        n_cur       = r_cur;
        n_pend      = o_re;
        n_pslot     = r_issued;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_pend) begin
            n_gb[r_pslot] = i_rdata;
            n_gv[r_pslot] = 1'b1;
        end
        if (can_issue) begin
            n_fidx   = r_fidx + 7'd1;
            n_issued = r_issued + 2'd1;
            if (!in_range) begin
                n_gb[r_issued] = 8'd0;
                n_gv[r_issued] = 1'b1;
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = '{out_char: ch, last_of_run: last};
            n_ocnt      = r_ocnt + 6'd1;
            case (r_phase)
                P_LEN: begin
                    n_phase = P_GRP;
                    n_k     = 2'd0;
                end
                P_GRP: begin
                    if (r_k == 2'd0) begin
                        n_cur    = r_gb;
                        n_gv     = '0;
                        n_issued = 2'd0;
                    end
                    if (r_k == 2'd3) begin
                        n_k    = 2'd0;
                        n_eidx = r_eidx + 7'd3;
                        if ((r_eidx + 7'd3) >= n7) begin
                            n_phase = P_NL;
                        end
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
                P_NL:    n_phase = P_T1;
                P_T1:    n_phase = P_T2;
                default: n_phase = P_T2;
            endcase
            if (last) begin
                n_busy = 1'b0;
            end
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end

        if (o_pop) begin
            n_busy   = 1'b1;
            n_job    = i_job;
            n_phase  = i_job.line ? P_LEN : P_T1;
            n_k      = 2'd0;
            n_eidx   = '0;
            n_ocnt   = '0;
            n_fidx   = '0;
            n_issued = 2'd0;
            n_gv     = '0;
            n_pend   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_k     <= n_k;
        r_eidx  <= n_eidx;
        r_ocnt  <= n_ocnt;
        r_fidx  <= n_fidx;
        r_gb    <= n_gb;
        r_cur   <= n_cur;
        r_pslot <= n_pslot;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= P_LEN;
            r_issued    <= 2'd0;
            r_gv        <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_issued    <= n_issued;
            r_gv        <= n_gv;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire
